@@ src/ps2_host_link_engine_defines.svh @@
// assertion macros for the link engine core
`ifndef PS2_HOST_LINK_ENGINE_DEFINES_SVH
`define PS2_HOST_LINK_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PS2HLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PS2HLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ps2hle_pkg.sv @@
package ps2hle_pkg;

    // item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    // receive shift register marks
    localparam logic [15:0] RX_SENTINEL   = 16'h0400;
    localparam logic [15:0] RX_STOP_BIT   = 16'h8000;
    localparam logic [15:0] RX_FRAME_MASK = 16'h8020;
    localparam logic [8:0]  RX_NINE_MASK  = 9'h1ff;

    // transmit frame bits
    localparam logic [9:0] TX_STOP   = 10'h200;
    localparam logic [9:0] TX_PARITY = 10'h100;

    // transmit edge counts
    localparam logic [3:0] EDGE_FIRST    = 4'd0;
    localparam logic [3:0] EDGE_LAST_BIT = 4'd8;
    localparam logic [3:0] EDGE_RELEASE  = 4'd9;
    localparam logic [3:0] EDGE_ACK      = 4'd10;

    // input word
    typedef struct packed {
        logic       kind;
        logic       data_line;
        logic [7:0] tx_byte;
    } in_t;

    // result word
    typedef struct packed {
        logic       drive_data_low;
        logic       frame_valid;
        logic [7:0] frame_byte;
        logic       parity_ok;
        logic       tx_done;
        logic       tx_error;
    } out_t;

endpackage

@@ src/ps2hle_in_stage.sv @@
module ps2hle_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ps2hle_pkg::in_t req,
    input  logic            take,
    output logic            item_valid,
    output ps2hle_pkg::in_t item
);

    logic            valid_reg;
    logic            valid_next;
    ps2hle_pkg::in_t word_reg;
    logic            load;

    // accept a new word when empty or when the held one moves on
    assign req_stall  = valid_reg && !take;
    assign load       = req_valid && !req_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = word_reg;

endmodule

@@ src/ps2hle_core.sv @@
`include "ps2_host_link_engine_defines.svh"

module ps2hle_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ps2hle_pkg::in_t  item,
    output ps2hle_pkg::out_t result
);

    logic [15:0] rx_shift_reg;
    logic [15:0] rx_shift_next;
    logic [9:0]  tx_shift_reg;
    logic [9:0]  tx_shift_next;
    logic [3:0]  edge_count_reg;
    logic [3:0]  edge_count_next;
    logic        tx_active_reg;
    logic        tx_active_next;
    logic        drive_level_reg;
    logic        drive_level_next;
    logic [15:0] rx_merged;
    logic [8:0]  rx_nine;

    // receive path helpers
    assign rx_merged = rx_shift_reg | (item.data_line ? ps2hle_pkg::RX_STOP_BIT : 16'h0000);
    assign rx_nine   = rx_merged[14:6] & ps2hle_pkg::RX_NINE_MASK;

    // next state and result for one word
    always_comb
    begin
        rx_shift_next    = rx_shift_reg;
        tx_shift_next    = tx_shift_reg;
        edge_count_next  = edge_count_reg;
        tx_active_next   = tx_active_reg;
        drive_level_next = drive_level_reg;
        result           = '0;

        if (item.kind == ps2hle_pkg::KIND_SEND)
        begin
            // load byte, odd parity and stop bit, request to send
            tx_shift_next    = ps2hle_pkg::TX_STOP | {2'b00, item.tx_byte}
                               | ((^item.tx_byte) ? 10'h000 : ps2hle_pkg::TX_PARITY);
            tx_active_next   = 1'b1;
            edge_count_next  = ps2hle_pkg::EDGE_FIRST;
            drive_level_next = 1'b1;
        end
        else if (tx_active_reg)
        begin
            if (edge_count_reg <= ps2hle_pkg::EDGE_LAST_BIT)
            begin
                // drive next bit, low for a zero
                drive_level_next = !tx_shift_reg[0];
                tx_shift_next    = {1'b0, tx_shift_reg[9:1]};
                edge_count_next  = edge_count_reg + 4'd1;
            end
            else if (edge_count_reg == ps2hle_pkg::EDGE_RELEASE)
            begin
                drive_level_next = 1'b0;
                edge_count_next  = ps2hle_pkg::EDGE_ACK;
            end
            else
            begin
                // ack edge ends the transmission
                result.tx_error  = item.data_line;
                result.tx_done   = 1'b1;
                tx_active_next   = 1'b0;
                drive_level_next = 1'b0;
                edge_count_next  = ps2hle_pkg::EDGE_FIRST;
                rx_shift_next    = ps2hle_pkg::RX_SENTINEL;
            end
        end
        else
        begin
            if (rx_merged[0])
            begin
                // sentinel reached the bottom: eleven bits are in
                if ((rx_merged & ps2hle_pkg::RX_FRAME_MASK) == ps2hle_pkg::RX_STOP_BIT)
                begin
                    result.frame_valid = 1'b1;
                    result.frame_byte  = rx_nine[7:0];
                    result.parity_ok   = ^rx_nine;
                end
                rx_shift_next = ps2hle_pkg::RX_SENTINEL;
            end
            else
            begin
                rx_shift_next = {1'b0, rx_merged[15:1]};
            end
        end

        result.drive_data_low = drive_level_next;
    end

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_shift_reg    <= ps2hle_pkg::RX_SENTINEL;
            tx_shift_reg    <= '0;
            edge_count_reg  <= ps2hle_pkg::EDGE_FIRST;
            tx_active_reg   <= 1'b0;
            drive_level_reg <= 1'b0;
        end
        else if (fire)
        begin
            rx_shift_reg    <= rx_shift_next;
            tx_shift_reg    <= tx_shift_next;
            edge_count_reg  <= edge_count_next;
            tx_active_reg   <= tx_active_next;
            drive_level_reg <= drive_level_next;
        end
    end

    `PS2HLE_ASSERT_NEXT(a_send_pulls_low, fire && (item.kind == ps2hle_pkg::KIND_SEND), drive_level_reg && tx_active_reg && (edge_count_reg == ps2hle_pkg::EDGE_FIRST), "send did not start a transmission")
    `PS2HLE_ASSERT_NOW(a_idle_count_zero, !tx_active_reg, (edge_count_reg == ps2hle_pkg::EDGE_FIRST) && !drive_level_reg, "idle link holds a count or drives data")
    `PS2HLE_ASSERT_NOW(a_count_range, 1'b1, edge_count_reg <= ps2hle_pkg::EDGE_ACK, "edge count past ack")
    `PS2HLE_ASSERT_NOW(a_sentinel_present, 1'b1, rx_shift_reg != 16'h0000, "receive sentinel lost")
    `PS2HLE_ASSERT_NOW(a_frame_only_idle, fire && result.frame_valid, !tx_active_reg && !result.tx_done, "frame reported during transmission")

endmodule

@@ src/ps2hle_out_stage.sv @@
module ps2hle_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  ps2hle_pkg::out_t result,
    output logic             take,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ps2hle_pkg::out_t rsp
);

    logic             valid_reg;
    logic             valid_next;
    ps2hle_pkg::out_t word_reg;

    // load when empty or when the held word is taken this cycle
    assign take       = item_valid && (!valid_reg || !rsp_stall);
    assign valid_next = take || (valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = word_reg;

endmodule

@@ src/ps2_host_link_engine.sv @@
// PS/2 host link engine
// req channel: one word per falling keyboard clock edge (kind 0, with the
// sampled data line) or per send request (kind 1, with tx_byte).
// rsp channel: exactly one result word for every request word, in order,
// carrying the data line drive level after that word, any received frame
// with its parity check, and the end-of-transmission flags.
// From acceptance to rsp_valid the word sits in the input register, then
// the frame logic loads the result register.
// Throughput is one word per cycle while rsp_stall is low; the limit is
// the single state update of the link registers per word.
// When rsp_stall is high the result word holds; the input register still
// takes one more word, and req_stall rises only once both registers hold.
// Reset clears the valid bits of both registers, loads the receive
// sentinel and releases the data line; no clearing pass is needed.
module ps2_host_link_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ps2hle_pkg::in_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ps2hle_pkg::out_t rsp
);

    logic             item_valid;
    ps2hle_pkg::in_t  item;
    ps2hle_pkg::out_t result;
    logic             take;

    // input register
    ps2hle_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // link state and frame logic
    ps2hle_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (take),
        .item   (item),
        .result (result)
    );

    // result register
    ps2hle_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // directed stimulus row: the word, whether a hand-typed result applies, and that result
    typedef struct packed {
        ps2hle_pkg::in_t  word;
        logic             hand_checked;
        ps2hle_pkg::out_t want;
    } dir_row_t;

    localparam ps2hle_pkg::out_t QUIET      = '0;
    localparam ps2hle_pkg::out_t LINE_LOW   = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam ps2hle_pkg::out_t GOT_FF_BAD = '{1'b0, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0};
    localparam ps2hle_pkg::out_t NO_ACK     = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1};

    localparam int RANDOM_WORDS = 1825;
    localparam int DIR_ROWS     = 26;

    // receive 0xff with a bad parity bit, send 0x00, restart with 0xff, no ack
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b1, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b1, GOT_FF_BAD},
        '{'{ps2hle_pkg::KIND_SEND, 1'b0, 8'h00}, 1'b1, LINE_LOW},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_SEND, 1'b1, 8'hff}, 1'b1, LINE_LOW},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'h00}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b0, 8'hff}, 1'b0, QUIET},
        '{'{ps2hle_pkg::KIND_EDGE, 1'b1, 8'h00}, 1'b1, NO_ACK}
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    ps2hle_pkg::in_t  req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    ps2hle_pkg::out_t rsp;

    // link state as the predictor sees it
    logic [15:0] rx_frame;
    logic [9:0]  tx_frame;
    logic [3:0]  edge_cnt;
    logic        sending;
    logic        line_low;

    ps2hle_pkg::out_t results_due [$];
    int               words_sent    = 0;
    int               fail_count    = 0;
    int               send_idle_pct = 24;
    int               recv_idle_pct = 67;

    ps2_host_link_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // predicts the result word for one word and advances the link state
    function automatic ps2hle_pkg::out_t link_predict(ps2hle_pkg::in_t w);
        ps2hle_pkg::out_t r;
        logic [8:0]       nine;
        r = '0;
        if (w.kind == ps2hle_pkg::KIND_SEND)
        begin
            // load byte, odd parity and stop bit, then pull the line low
            tx_frame = ps2hle_pkg::TX_STOP | {2'b00, w.tx_byte};
            if (!(^w.tx_byte))
                tx_frame = tx_frame | ps2hle_pkg::TX_PARITY;
            sending  = 1'b1;
            edge_cnt = ps2hle_pkg::EDGE_FIRST;
            line_low = 1'b1;
        end
        else if (sending)
        begin
            if (edge_cnt <= ps2hle_pkg::EDGE_LAST_BIT)
            begin
                line_low = !tx_frame[0];
                tx_frame = tx_frame >> 1;
                edge_cnt = edge_cnt + 4'd1;
            end
            else if (edge_cnt == ps2hle_pkg::EDGE_RELEASE)
            begin
                line_low = 1'b0;
                edge_cnt = ps2hle_pkg::EDGE_ACK;
            end
            else
            begin
                // ack edge ends the transmission
                r.tx_error = w.data_line;
                r.tx_done  = 1'b1;
                sending    = 1'b0;
                line_low   = 1'b0;
                edge_cnt   = ps2hle_pkg::EDGE_FIRST;
                rx_frame   = ps2hle_pkg::RX_SENTINEL;
            end
        end
        else
        begin
            // receive: shift in until the sentinel reaches bit 0
            if (w.data_line)
                rx_frame = rx_frame | ps2hle_pkg::RX_STOP_BIT;
            if (rx_frame[0])
            begin
                if ((rx_frame & ps2hle_pkg::RX_FRAME_MASK) == ps2hle_pkg::RX_STOP_BIT)
                begin
                    nine          = rx_frame[14:6];
                    r.frame_valid = 1'b1;
                    r.frame_byte  = nine[7:0];
                    r.parity_ok   = ^nine;
                end
                rx_frame = ps2hle_pkg::RX_SENTINEL;
            end
            else
            begin
                rx_frame = rx_frame >> 1;
            end
        end
        r.drive_data_low = line_low;
        return r;
    endfunction

    function automatic ps2hle_pkg::in_t edge_word(logic level);
        ps2hle_pkg::in_t w;
        w = '{ps2hle_pkg::KIND_EDGE, level, 8'($urandom)};
        return w;
    endfunction

    // presents one word at the falling edge and holds it until taken
    task automatic send_word(ps2hle_pkg::in_t w, logic hand_checked, ps2hle_pkg::out_t want);
        ps2hle_pkg::out_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = link_predict(w);
        results_due.push_back(hand_checked ? want : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 100)
                $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // receiver stalls at random
    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        ps2hle_pkg::out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 100)
                    $display("%0t unexpected result word: expected none, actual %h",
                             $time, rsp);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("drive_data_low", 8'(want.drive_data_low),
                            8'(rsp.drive_data_low));
                check_field("frame_valid", 8'(want.frame_valid), 8'(rsp.frame_valid));
                check_field("frame_byte", want.frame_byte, rsp.frame_byte);
                check_field("parity_ok", 8'(want.parity_ok), 8'(rsp.parity_ok));
                check_field("tx_done", 8'(want.tx_done), 8'(rsp.tx_done));
                check_field("tx_error", 8'(want.tx_error), 8'(rsp.tx_error));
            end
        end
    end

    initial
    begin
        ps2hle_pkg::in_t w;
        logic [10:0]     frame_bits;
        logic [7:0]      b;
        logic            par;
        int              pick;
        int              cut;
        int              n;
        int              k;

        rx_frame = ps2hle_pkg::RX_SENTINEL;
        tx_frame = '0;
        edge_cnt = ps2hle_pkg::EDGE_FIRST;
        sending  = 1'b0;
        line_low = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (k = 0; k < DIR_ROWS; k++)
            send_word(DIRECTED[k].word, DIRECTED[k].hand_checked, DIRECTED[k].want);

        // random: mostly whole frames and transmissions, some noise
        while (words_sent < DIR_ROWS + RANDOM_WORDS)
        begin
            if (words_sent >= DIR_ROWS + 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (words_sent >= DIR_ROWS + RANDOM_WORDS / 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 24;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // received frame, mostly well formed
                b   = 8'($urandom);
                par = !(^b);
                if ($urandom_range(0, 4) == 0)
                    par = !par;
                frame_bits = {1'b1, par, b, 1'b0};
                if ($urandom_range(0, 9) == 0)
                    frame_bits[0] = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    frame_bits[10] = 1'b0;
                for (k = 0; k < 11; k++)
                    send_word(edge_word(frame_bits[k]), 1'b0, QUIET);
            end
            else if (pick < 80)
            begin
                // transmission, sometimes restarted part way
                w = '{ps2hle_pkg::KIND_SEND, 1'($urandom), 8'($urandom)};
                send_word(w, 1'b0, QUIET);
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(0, 10);
                    for (k = 0; k < cut; k++)
                        send_word(edge_word(1'($urandom)), 1'b0, QUIET);
                    w = '{ps2hle_pkg::KIND_SEND, 1'($urandom), 8'($urandom)};
                    send_word(w, 1'b0, QUIET);
                end
                for (k = 0; k < 10; k++)
                    send_word(edge_word(1'($urandom)), 1'b0, QUIET);
                send_word(edge_word($urandom_range(0, 3) == 0), 1'b0, QUIET);
            end
            else
            begin
                // noise words
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                begin
                    w = '{($urandom_range(0, 9) == 0) ? ps2hle_pkg::KIND_SEND
                                                      : ps2hle_pkg::KIND_EDGE,
                          1'($urandom), 8'($urandom)};
                    send_word(w, 1'b0, QUIET);
                end
            end
        end

        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
